>>> hdl/meter_frame_group_checker_top_assert.svh
// assertion macros for the meter frame group checker
`ifndef METER_FRAME_GROUP_CHECKER_TOP_ASSERT_SVH
`define METER_FRAME_GROUP_CHECKER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MFGC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("meter frame group checker assertion failed");

// next-cycle implication, disabled in reset
`define MFGC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("meter frame group checker assertion failed");

`endif

>>> hdl/mfgc_pkg.sv
// shared types and constants of the meter frame group checker
package mfgc_pkg;

    localparam int unsigned BYTE_W = 7;
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW = $clog2(Q_DEPTH);

    localparam logic [BYTE_W-1:0] STX_CODE = 7'h02;
    localparam logic [BYTE_W-1:0] ETX_CODE = 7'h03;
    localparam logic [BYTE_W-1:0] LF_CODE = 7'h0A;
    localparam logic [BYTE_W-1:0] CR_CODE = 7'h0D;
    localparam logic [BYTE_W-1:0] SP_CODE = 7'h20;

    localparam logic [5:0] CHECK_MASK = 6'd63;
    localparam logic [BYTE_W-1:0] CHECK_BIAS = 7'd32;

    localparam logic [1:0] CLS_DATA = 2'd0;
    localparam logic [1:0] CLS_LF = 2'd1;
    localparam logic [1:0] CLS_CR = 2'd2;
    localparam logic [1:0] CLS_ETX = 2'd3;

    typedef struct packed {
        logic [1:0] cls;
        logic [BYTE_W-1:0] data;
    } t_qitem;

    typedef struct packed {
        logic push;
        t_qitem item;
    } t_qwrite;

endpackage

>>> hdl/mfgc_queue.sv
// short request queue between front and back
module mfgc_queue
    import mfgc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_qwrite i_wr,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_not_empty,
    output t_qitem  o_item
);

    t_qitem r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_AW:0] r_count, n_count;
    logic do_push, do_pop;

    assign o_full = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_item = r_mem[r_rd_ptr];
    assign do_push = i_wr.push && !o_full;
    assign do_pop = i_pop && o_not_empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!do_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr.item;
        end
    end

endmodule

>>> hdl/mfgc_front.sv
// front end: frame tracking and byte classification
module mfgc_front
    import mfgc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_q_full,
    output t_qwrite           o_wr
);

    logic r_in_frame, n_in_frame;
    logic r_last_was_etx, n_last_was_etx;
    logic accept;

    assign accept = i_valid && !i_q_full;

    always_comb begin
        n_in_frame = r_in_frame;
        n_last_was_etx = r_last_was_etx;
        o_wr.push = 1'b0;
        o_wr.item.data = i_rx_byte;
        case (i_rx_byte)
            ETX_CODE: o_wr.item.cls = CLS_ETX;
            LF_CODE:  o_wr.item.cls = CLS_LF;
            CR_CODE:  o_wr.item.cls = CLS_CR;
            default:  o_wr.item.cls = CLS_DATA;
        endcase
        if (accept) begin
            if (!r_in_frame) begin
                if (i_rx_byte == STX_CODE && r_last_was_etx) begin
                    n_in_frame = 1'b1;
                end
                n_last_was_etx = (i_rx_byte == ETX_CODE);
            end else begin
                o_wr.push = 1'b1;
                n_last_was_etx = (i_rx_byte == ETX_CODE);
                if (i_rx_byte == ETX_CODE) begin
                    n_in_frame = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_last_was_etx <= 1'b0;
        end else begin
            r_in_frame <= n_in_frame;
            r_last_was_etx <= n_last_was_etx;
        end
    end

endmodule

>>> hdl/mfgc_back.sv
// back end: group checksum and result register
module mfgc_back
    import mfgc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_not_empty,
    input  t_qitem            i_q_item,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_event_kind,
    output logic              o_checksum_good,
    output logic              o_malformed,
    output logic [BYTE_W-1:0] o_computed_check,
    output logic [BYTE_W-1:0] o_received_check
);

    localparam logic [1:0] FP_LABEL = 2'd0;
    localparam logic [1:0] FP_VALUE = 2'd1;
    localparam logic [1:0] FP_CHECK = 2'd2;
    localparam logic [1:0] FP_DONE = 2'd3;

    logic [1:0] r_field_pos, n_field_pos;
    logic [7:0] r_sum, n_sum;
    logic [BYTE_W-1:0] r_check_byte, n_check_byte;
    logic r_check_seen, n_check_seen;

    logic r_out_valid, n_out_valid;
    logic r_event_kind, n_event_kind;
    logic r_good, n_good;
    logic r_bad, n_bad;
    logic [BYTE_W-1:0] r_computed, n_computed;
    logic [BYTE_W-1:0] r_received, n_received;

    logic out_free;
    logic [BYTE_W-1:0] computed;
    logic group_bad;

    assign out_free = !r_out_valid || !i_stall;
    assign o_q_pop = i_q_not_empty && out_free;
    assign computed = {1'b0, r_sum[5:0] & CHECK_MASK} + CHECK_BIAS;
    assign group_bad = !(r_field_pos == FP_DONE && r_check_seen);

    always_comb begin
        n_field_pos = r_field_pos;
        n_sum = r_sum;
        n_check_byte = r_check_byte;
        n_check_seen = r_check_seen;
        n_out_valid = r_out_valid && i_stall;
        n_event_kind = r_event_kind;
        n_good = r_good;
        n_bad = r_bad;
        n_computed = r_computed;
        n_received = r_received;
        if (o_q_pop) begin
            case (i_q_item.cls)
                CLS_ETX: begin
                    n_out_valid = 1'b1;
                    n_event_kind = 1'b1;
                    n_good = 1'b0;
                    n_bad = 1'b0;
                    n_computed = '0;
                    n_received = '0;
                    n_field_pos = FP_LABEL;
                    n_sum = '0;
                    n_check_byte = '0;
                    n_check_seen = 1'b0;
                end
                CLS_LF: begin
                    n_field_pos = FP_LABEL;
                    n_sum = '0;
                    n_check_byte = '0;
                    n_check_seen = 1'b0;
                end
                CLS_CR: begin
                    n_out_valid = 1'b1;
                    n_event_kind = 1'b0;
                    n_good = !group_bad && (computed == r_check_byte);
                    n_bad = group_bad;
                    n_computed = computed;
                    n_received = r_check_seen ? r_check_byte : '0;
                    n_field_pos = FP_LABEL;
                    n_sum = '0;
                    n_check_byte = '0;
                    n_check_seen = 1'b0;
                end
                default: begin
                    case (r_field_pos)
                        FP_LABEL: begin
                            n_sum = r_sum + {1'b0, i_q_item.data};
                            if (i_q_item.data == SP_CODE) begin
                                n_field_pos = FP_VALUE;
                            end
                        end
                        FP_VALUE: begin
                            if (i_q_item.data == SP_CODE) begin
                                n_field_pos = FP_CHECK;
                            end else begin
                                n_sum = r_sum + {1'b0, i_q_item.data};
                            end
                        end
                        FP_CHECK: begin
                            n_check_byte = i_q_item.data;
                            n_check_seen = 1'b1;
                            n_field_pos = FP_DONE;
                        end
                        default: begin
                            n_field_pos = r_field_pos;
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_pos <= FP_LABEL;
            r_sum <= '0;
            r_check_byte <= '0;
            r_check_seen <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_field_pos <= n_field_pos;
            r_sum <= n_sum;
            r_check_byte <= n_check_byte;
            r_check_seen <= n_check_seen;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_event_kind <= n_event_kind;
        r_good <= n_good;
        r_bad <= n_bad;
        r_computed <= n_computed;
        r_received <= n_received;
    end

    assign o_valid = r_out_valid;
    assign o_event_kind = r_event_kind;
    assign o_checksum_good = r_good;
    assign o_malformed = r_bad;
    assign o_computed_check = r_computed;
    assign o_received_check = r_received;

endmodule

>>> hdl/meter_frame_group_checker_top.sv
// top level of the meter frame group checker
//
// channel   direction  handshake            payload
// rx        in         i_valid / o_stall    i_rx_byte
// result    out        o_valid / i_stall    o_event_kind o_checksum_good o_malformed
//                                           o_computed_check o_received_check
//
// one byte accepted per cycle while the 4-entry queue has room
// a result passes from its byte through the queue, then through the result register
// synchronous active-low reset empties the queue and leaves the frame
// a stalled result holds; bytes keep coming until the queue fills
module meter_frame_group_checker_top
    import mfgc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_event_kind,
    output logic              o_checksum_good,
    output logic              o_malformed,
    output logic [BYTE_W-1:0] o_computed_check,
    output logic [BYTE_W-1:0] o_received_check
);

    t_qwrite q_wr;
    t_qitem q_item;
    logic q_full;
    logic q_not_empty;
    logic q_pop;

    assign o_stall = q_full;

    mfgc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .i_q_full  (q_full),
        .o_wr      (q_wr)
    );

    mfgc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (q_wr),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_item      (q_item)
    );

    mfgc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_not_empty    (q_not_empty),
        .i_q_item         (q_item),
        .o_q_pop          (q_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_event_kind     (o_event_kind),
        .o_checksum_good  (o_checksum_good),
        .o_malformed      (o_malformed),
        .o_computed_check (o_computed_check),
        .o_received_check (o_received_check)
    );

endmodule

>>> hdl/mfgc_checker.sv
// port-level assertions for the meter frame group checker
`include "meter_frame_group_checker_top_assert.svh"

module mfgc_checker
    import mfgc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              o_valid,
    input  logic              i_stall,
    input  logic              o_event_kind,
    input  logic              o_checksum_good,
    input  logic              o_malformed,
    input  logic [BYTE_W-1:0] o_computed_check,
    input  logic [BYTE_W-1:0] o_received_check
);

    `MFGC_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_event_kind) && $stable(o_checksum_good) &&
        $stable(o_malformed) && $stable(o_computed_check) && $stable(o_received_check))
    `MFGC_ASSERT_IMPLY(a_frame_end_clear, i_clk, i_rst_n, o_valid && o_event_kind,
        !o_checksum_good && !o_malformed && o_computed_check == '0 &&
        o_received_check == '0)
    `MFGC_ASSERT_IMPLY(a_check_range, i_clk, i_rst_n, o_valid && !o_event_kind,
        o_computed_check >= 7'd32 && o_computed_check <= 7'd95)
    `MFGC_ASSERT_IMPLY(a_good_consistent, i_clk, i_rst_n, o_valid && o_checksum_good,
        !o_malformed && !o_event_kind && o_computed_check == o_received_check)

endmodule

bind meter_frame_group_checker_top mfgc_checker u_mfgc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_event_kind     (o_event_kind),
    .o_checksum_good  (o_checksum_good),
    .o_malformed      (o_malformed),
    .o_computed_check (o_computed_check),
    .o_received_check (o_received_check)
);
